@@ hdl/qepi_pkg.sv @@
// Shared types and constants for the quad edge pressure interpolator.
package qepi_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned AluW    = 2 * DiffW;
  localparam int unsigned RootW   = DiffW;
  localparam int unsigned RemW    = RootW + 3;
  localparam int unsigned RatioW  = 17;
  localparam int unsigned ProdW   = DiffW + RatioW + 1;
  localparam int unsigned SumW    = CoordW + 2;
  localparam int unsigned CntW    = 6;
  localparam int unsigned FracW   = 16;

  localparam logic [RatioW-1:0] RatioOne = RatioW'(1) << FracW;
  localparam logic [ProdW-1:0]  RoundHalf = ProdW'(1) << (FracW - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_LOAD,
    ST_SQ,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_CMP,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
    logic            sub;
  } alu_req_t;

  typedef struct packed {
    logic [AluW-1:0] sum;
    logic            borrow;
  } alu_rsp_t;

endpackage

@@ hdl/quad_edge_pressure_interpolator.sv @@
// Top level: sequencer and datapath registers around the shared add/subtract unit.
//
//  channel | signals                     | payload
//  --------+-----------------------------+------------------------------------------
//  in      | s_tvalid s_tready s_tdata   | edge coordinates and corner pressures,
//          | s_tlast                     | tlast marks the last edge of the quad
//  out     | m_tvalid m_tready m_tdata   | midside and centre pressure,
//          | m_tuser                     | tuser flags the centre value
//
// Each edge runs through the single 66-bit add/subtract unit: four 33-step
// shift-add squares, two 33-step bit-serial roots, a 17-step divide (skipped when
// the ratio needs no divide), plus load, compare, multiply, finish and idle states.
// Synchronous reset clears the sequencer, output valid and the corner sum.
// A new edge is taken only in idle; a finished result waits in the output
// register while the next edge is processed, and the sequencer holds at the
// end until that register is free.
module quad_edge_pressure_interpolator
  import qepi_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, mid_x, mid_y, end_x, end_y, start_pressure, end_pressure
  input  logic [255:0] s_tdata,
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // mid_pressure, center_pressure
  output logic [63:0]  m_tdata,
  // center_valid
  output logic [0:0]   m_tuser
);

  state_t state, state_next;

  logic signed [CoordW-1:0] sx, sy, mx, my, ex, ey, p0, p1;
  logic                     last;
  logic [1:0]               pass;
  logic [CntW-1:0]          cnt;
  logic [AluW-1:0]          acc, mcand, rad;
  logic [DiffW-1:0]         mplier;
  logic [RemW-1:0]          rem;
  logic [RootW-1:0]         root, d0, d;
  logic [RatioW-1:0]        ratio;
  logic signed [ProdW-1:0]  prod;
  logic [SumW-1:0]          corner_sum;

  logic signed [DiffW-1:0]  dsel, pdiff;
  logic [DiffW-1:0]         dmag;
  logic [RemW-1:0]          remsh, divt;
  logic [ProdW-1:0]         rnd;
  logic [SumW-1:0]          sum_new;
  logic                     out_free, sq_end, sqrt_end, div_end;
  alu_req_t                 req;
  alu_rsp_t                 rsp;

  qepi_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  always_comb begin
    case (pass)
      2'd0:    dsel = DiffW'(mx) - DiffW'(sx);
      2'd1:    dsel = DiffW'(my) - DiffW'(sy);
      2'd2:    dsel = DiffW'(ex) - DiffW'(sx);
      default: dsel = DiffW'(ey) - DiffW'(sy);
    endcase
  end

  assign dmag     = dsel[DiffW-1] ? DiffW'(-dsel) : DiffW'(dsel);
  assign remsh    = {rem[RemW-3:0], rad[AluW-1 -: 2]};
  assign divt     = (cnt == '0) ? rem : {rem[RemW-2:0], 1'b0};
  assign pdiff    = $signed({p1[CoordW-1], p1}) - $signed({p0[CoordW-1], p0});
  assign rnd      = prod + RoundHalf;
  assign sum_new  = corner_sum + {{(SumW-CoordW){p0[CoordW-1]}}, p0};
  assign out_free = !m_tvalid || m_tready;
  assign sq_end   = (cnt == CntW'(DiffW - 1));
  assign sqrt_end = (cnt == CntW'(RootW - 1));
  assign div_end  = (cnt == CntW'(RatioW - 1));
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    req = '0;
    unique case (state)
      ST_SQ: begin
        req.a = acc;
        req.b = mplier[0] ? mcand : '0;
      end
      ST_SQRT: begin
        req.a   = AluW'(remsh);
        req.b   = AluW'({root, 2'b01});
        req.sub = 1'b1;
      end
      ST_CMP: begin
        req.a   = AluW'(d);
        req.b   = AluW'(d0);
        req.sub = 1'b1;
      end
      ST_DIV: begin
        req.a   = AluW'(divt);
        req.b   = AluW'(d);
        req.sub = 1'b1;
      end
      default: req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (s_tvalid) state_next = ST_SQ_LOAD;
      ST_SQ_LOAD:   state_next = ST_SQ;
      ST_SQ: begin
        if (sq_end) state_next = pass[0] ? ST_SQRT_LOAD : ST_SQ_LOAD;
      end
      ST_SQRT_LOAD: state_next = ST_SQRT;
      ST_SQRT: begin
        if (sqrt_end) state_next = (pass == 2'd2) ? ST_SQ_LOAD : ST_CMP;
      end
      ST_CMP: begin
        if (d == '0 || rsp.borrow) state_next = ST_MUL;
        else state_next = ST_DIV;
      end
      ST_DIV:       if (div_end) state_next = ST_MUL;
      ST_MUL:       state_next = ST_FIN;
      ST_FIN:       if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        sx   <= s_tdata[31:0];
        sy   <= s_tdata[63:32];
        mx   <= s_tdata[95:64];
        my   <= s_tdata[127:96];
        ex   <= s_tdata[159:128];
        ey   <= s_tdata[191:160];
        p0   <= s_tdata[223:192];
        p1   <= s_tdata[255:224];
        last <= s_tlast;
        pass <= '0;
      end
      ST_SQ_LOAD: begin
        mcand  <= AluW'(dmag);
        mplier <= dmag;
        cnt    <= '0;
        if (!pass[0]) acc <= '0;
      end
      ST_SQ: begin
        acc    <= rsp.sum;
        mcand  <= {mcand[AluW-2:0], 1'b0};
        mplier <= {1'b0, mplier[DiffW-1:1]};
        cnt    <= cnt + CntW'(1);
        if (sq_end) pass <= pass + 2'd1;
      end
      ST_SQRT_LOAD: begin
        rad  <= acc;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end
      ST_SQRT: begin
        rad <= {rad[AluW-3:0], 2'b00};
        cnt <= cnt + CntW'(1);
        if (rsp.borrow) begin
          rem  <= remsh;
          root <= {root[RootW-2:0], 1'b0};
        end else begin
          rem  <= rsp.sum[RemW-1:0];
          root <= {root[RootW-2:0], 1'b1};
        end
        if (sqrt_end) begin
          if (pass == 2'd2) d0 <= {root[RootW-2:0], ~rsp.borrow};
          else d <= {root[RootW-2:0], ~rsp.borrow};
        end
      end
      ST_CMP: begin
        rem <= RemW'(d0);
        cnt <= '0;
        if (d == '0) ratio <= '0;
        else if (rsp.borrow) ratio <= RatioOne;
        else ratio <= '0;
      end
      ST_DIV: begin
        cnt <= cnt + CntW'(1);
        if (rsp.borrow) begin
          rem   <= divt;
          ratio <= {ratio[RatioW-2:0], 1'b0};
        end else begin
          rem   <= rsp.sum[RemW-1:0];
          ratio <= {ratio[RatioW-2:0], 1'b1};
        end
      end
      ST_MUL: begin
        prod <= ProdW'(pdiff) * ProdW'($signed({1'b0, ratio}));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      corner_sum <= '0;
    end else begin
      if (state == ST_FIN && out_free) begin
        m_tvalid   <= 1'b1;
        corner_sum <= last ? '0 : sum_new;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      m_tdata[31:0]  <= p0 + rnd[FracW +: CoordW];
      m_tdata[63:32] <= last ? sum_new[SumW-1:2] : '0;
      m_tuser        <= last;
    end
  end

endmodule

@@ hdl/qepi_alu.sv @@
// Shared add/subtract unit used by the square, root, compare and divide steps.
module qepi_alu
  import qepi_pkg::*;
(
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [AluW:0] full;

  assign full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)} + {{AluW{1'b0}}, req.sub};
  assign rsp.sum    = full[AluW-1:0];
  assign rsp.borrow = req.sub & ~full[AluW];

endmodule
